// ----- hdl/mi3_pkg.sv -----
// Package for the 3x3 fixed-point matrix inverse.
// Holds the number format, pipeline widths, item types and cofactor index table.
// No dependencies.
package mi3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int EW = 32;            // element width
	localparam int PW = 2 * EW;        // element product
	localparam int AW = PW + 1;        // cofactor
	localparam int TW = EW + AW;       // element times cofactor
	localparam int DW = TW + 2;        // determinant, sum of three
	localparam int NW = AW + 2 * FRAC_BITS; // shifted numerator magnitude
	localparam int QW = EW + 2;        // quotient bits kept, top bit flags overflow
	localparam int RW = DW + QW - 1;   // partial remainder

	// per cofactor: a*b - c*d, indices into row-major elements
	localparam int unsigned COF_IDX [9][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 8, 1}, '{1, 5, 4, 2},
		'{5, 6, 8, 3}, '{0, 8, 6, 2}, '{2, 3, 5, 0},
		'{3, 7, 6, 4}, '{1, 6, 7, 0}, '{0, 4, 3, 1}
	};

	typedef struct packed {
		logic signed [EW-1:0] in_r0c0;
		logic signed [EW-1:0] in_r0c1;
		logic signed [EW-1:0] in_r0c2;
		logic signed [EW-1:0] in_r1c0;
		logic signed [EW-1:0] in_r1c1;
		logic signed [EW-1:0] in_r1c2;
		logic signed [EW-1:0] in_r2c0;
		logic signed [EW-1:0] in_r2c1;
		logic signed [EW-1:0] in_r2c2;
	} mi3_in_t;

	typedef struct packed {
		logic signed [EW-1:0] out_r0c0;
		logic signed [EW-1:0] out_r0c1;
		logic signed [EW-1:0] out_r0c2;
		logic signed [EW-1:0] out_r1c0;
		logic signed [EW-1:0] out_r1c1;
		logic signed [EW-1:0] out_r1c2;
		logic signed [EW-1:0] out_r2c0;
		logic signed [EW-1:0] out_r2c1;
		logic signed [EW-1:0] out_r2c2;
		logic                 singular;
	} mi3_out_t;

endpackage

// ----- hdl/mi3_ifs.sv -----
// Valid/ready channel interfaces for the matrix inverse.
// Depends on mi3_pkg for the item types.
interface mi3_in_if;
	logic            valid;
	logic            ready;
	mi3_pkg::mi3_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
	logic             valid;
	logic             ready;
	mi3_pkg::mi3_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/matrix3x3_inverse.sv -----
// 3x3 signed fixed-point matrix inverse by the adjugate, fully pipelined.
// Depends on mi3_pkg and the channel interfaces in mi3_ifs.sv.
//
// Usage:
//   mat_in carries one matrix per item (nine Q16.16 elements, row major);
//   mat_out carries the inverse, saturated to Q16.16, and a singular flag
//   that is set, with all elements zero, when the determinant is zero.
//   Both channels move an item on a clock edge with valid and ready high.
//   From acceptance to out valid an item passes six arithmetic
//   stages (products, cofactors, split determinant products, two adds,
//   magnitudes), 34 restoring divider stages (one quotient bit each, nine
//   lanes side by side) and the output register.
//   Throughput is one item per cycle unless stalled; the divider chain sets depth.
//   When the receiver stalls, the output register holds its item and a skid
//   register catches the one behind it; the pipeline then freezes and
//   mat_in.ready drops until the output drains. ready is a register output.
//   arst_n clears every valid bit; the data registers have no reset.
module matrix3x3_inverse (
	input  logic       clk,
	input  logic       arst_n,
	mi3_in_if.sink     mat_in,
	mi3_out_if.source  mat_out
);
	import mi3_pkg::*;

	logic en;
	logic skid_v_q, out_v_q;
	mi3_out_t skid_q, out_q, res;

	logic signed [EW-1:0] e [9];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PW-1:0] prod_s1 [18];
	logic signed [EW-1:0] e_s1 [3], e_s2 [3];
	logic signed [AW-1:0] adj_s2 [9], adj_s3 [9], adj_s4 [9], adj_s5 [9];
	logic signed [AW-1:0] ph_s3 [3], pl_s3 [3];
	logic signed [TW-1:0] t_s4 [3];
	logic signed [DW-1:0] det_s5;

	// index 0 is stage 6 (magnitudes), index j holds quotient bits down to QW-j
	logic          dv_v_s6    [QW+1];
	logic [RW-1:0] dv_rem_s6  [QW+1][9];
	logic [QW-1:0] dv_q_s6    [QW+1][9];
	logic          dv_neg_s6  [QW+1][9];
	logic [DW-1:0] dv_d_s6    [QW+1];
	logic          dv_sing_s6 [QW+1];

	assign en = !skid_v_q;
	assign mat_in.ready = en;

	assign e[0] = mat_in.data.in_r0c0;
	assign e[1] = mat_in.data.in_r0c1;
	assign e[2] = mat_in.data.in_r0c2;
	assign e[3] = mat_in.data.in_r1c0;
	assign e[4] = mat_in.data.in_r1c1;
	assign e[5] = mat_in.data.in_r1c2;
	assign e[6] = mat_in.data.in_r2c0;
	assign e[7] = mat_in.data.in_r2c1;
	assign e[8] = mat_in.data.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int j = 0; j <= QW; j++) dv_v_s6[j] <= 1'b0;
		end else if (en) begin
			v_s1 <= mat_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_v_s6[0] <= v_s5;
			for (int j = 1; j <= QW; j++) dv_v_s6[j] <= dv_v_s6[j-1];
		end
	end

	// arithmetic front end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				prod_s1[2*i]   <= e[COF_IDX[i][0]] * e[COF_IDX[i][1]];
				prod_s1[2*i+1] <= e[COF_IDX[i][2]] * e[COF_IDX[i][3]];
				adj_s2[i] <= AW'(prod_s1[2*i]) - AW'(prod_s1[2*i+1]);
				adj_s3[i] <= adj_s2[i];
				adj_s4[i] <= adj_s3[i];
				adj_s5[i] <= adj_s4[i];
			end
			for (int k = 0; k < 3; k++) begin
				e_s1[k] <= e[k];
				e_s2[k] <= e_s1[k];
				// first row against cofactors 0, 3, 6; cofactor split in high and low words
				ph_s3[k] <= e_s2[k] * $signed(adj_s2[3*k][AW-1:EW]);
				pl_s3[k] <= e_s2[k] * $signed({1'b0, adj_s2[3*k][EW-1:0]});
				t_s4[k] <= ({{(TW-AW){ph_s3[k][AW-1]}}, ph_s3[k]} << EW)
					+ {{(TW-AW){pl_s3[k][AW-1]}}, pl_s3[k]};
			end
			det_s5 <= {{(DW-TW){t_s4[0][TW-1]}}, t_s4[0]}
				+ {{(DW-TW){t_s4[1][TW-1]}}, t_s4[1]}
				+ {{(DW-TW){t_s4[2][TW-1]}}, t_s4[2]};
		end
	end

	// magnitudes and signs
	always_ff @(posedge clk) begin
		logic [AW-1:0] amag;
		if (en) begin
			dv_d_s6[0] <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			dv_sing_s6[0] <= (det_s5 == '0);
			for (int i = 0; i < 9; i++) begin
				amag = adj_s5[i][AW-1] ? AW'(-adj_s5[i]) : AW'(adj_s5[i]);
				dv_rem_s6[0][i] <= RW'({amag, {(2*FRAC_BITS){1'b0}}});
				dv_q_s6[0][i] <= '0;
				dv_neg_s6[0][i] <= adj_s5[i][AW-1] ^ det_s5[DW-1];
			end
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int K = QW - j;
		logic [RW-1:0] dsh;
		assign dsh = RW'(dv_d_s6[j-1]) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_d_s6[j] <= dv_d_s6[j-1];
				dv_sing_s6[j] <= dv_sing_s6[j-1];
				for (int i = 0; i < 9; i++) begin
					dv_neg_s6[j][i] <= dv_neg_s6[j-1][i];
					if (dv_rem_s6[j-1][i] >= dsh) begin
						dv_rem_s6[j][i] <= dv_rem_s6[j-1][i] - dsh;
						dv_q_s6[j][i] <= {dv_q_s6[j-1][i][QW-2:0], 1'b1};
					end else begin
						dv_rem_s6[j][i] <= dv_rem_s6[j-1][i];
						dv_q_s6[j][i] <= {dv_q_s6[j-1][i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// saturation; quotient top bit means the true quotient reached 2^(QW-1)
	logic signed [EW-1:0] r [9];
	always_comb begin
		logic [QW-1:0] q;
		for (int i = 0; i < 9; i++) begin
			q = dv_q_s6[QW][i];
			if (dv_sing_s6[QW]) begin
				r[i] = '0;
			end else if (dv_neg_s6[QW][i]) begin
				if (q > QW'({1'b1, {(EW-1){1'b0}}})) r[i] = {1'b1, {(EW-1){1'b0}}};
				else r[i] = -$signed(q[EW-1:0]);
			end else begin
				if (q > QW'({1'b0, {(EW-1){1'b1}}})) r[i] = {1'b0, {(EW-1){1'b1}}};
				else r[i] = $signed(q[EW-1:0]);
			end
		end
		res.out_r0c0 = r[0];
		res.out_r0c1 = r[1];
		res.out_r0c2 = r[2];
		res.out_r1c0 = r[3];
		res.out_r1c1 = r[4];
		res.out_r1c2 = r[5];
		res.out_r2c0 = r[6];
		res.out_r2c1 = r[7];
		res.out_r2c2 = r[8];
		res.singular = dv_sing_s6[QW];
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || mat_out.ready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= dv_v_s6[QW];
			end
		end else if (dv_v_s6[QW]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || mat_out.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en) begin
			skid_q <= res;
		end
	end

	assign mat_out.valid = out_v_q;
	assign mat_out.data = out_q;
endmodule

// ----- hdl/mi3_chk.sv -----
// Port-level checker for the matrix inverse, bound to the top level.
// Depends on mi3_pkg for the result type.
module mi3_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input mi3_pkg::mi3_out_t out_data
);
	import mi3_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			out_data.out_r0c0 == '0 && out_data.out_r0c1 == '0 &&
			out_data.out_r0c2 == '0 && out_data.out_r1c0 == '0 &&
			out_data.out_r1c1 == '0 && out_data.out_r1c2 == '0 &&
			out_data.out_r2c0 == '0 && out_data.out_r2c1 == '0 &&
			out_data.out_r2c2 == '0)
		else $error("singular item with nonzero elements");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input held off with no result waiting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input held off without an output stall");
endmodule

bind matrix3x3_inverse mi3_chk u_mi3_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat_in.valid),
	.in_ready  (mat_in.ready),
	.out_valid (mat_out.valid),
	.out_ready (mat_out.ready),
	.out_data  (mat_out.data)
);
